[rtl/gbc_pkg.sv]
// Shared types and constants of the generational buffer cache.
// Depends on nothing; every file of the block but gbc_ram imports it.
`default_nettype none

package gbc_pkg;

  // Fixed field widths of the two channels
  localparam int OP_W         = 2;
  localparam int IN_KEY_W     = 64;
  localparam int IN_HANDLE_W  = 32;
  localparam int OUT_HANDLE_W = 32;

  // Operation codes of an input word
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP   = 2'd0,
    OP_REGISTER = 2'd1,
    OP_REFRESH  = 2'd2,
    OP_PURGE    = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // latch the accepted word, restart the scan
    logic scan;    // issue a table read and advance the address
    logic finish;  // commit the table update and load the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_addr;  // the read being issued is the last entry
    logic out_free;   // the result register can take a word this cycle
  } status_t;

endpackage

`default_nettype wire

[rtl/gbc_if.sv]
// Channel interfaces of the generational buffer cache: request and result.
// Depends on gbc_pkg for the field widths.
`default_nettype none

interface gbc_in_if import gbc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [IN_KEY_W-1:0]    buffer_key;
  logic [IN_HANDLE_W-1:0] buffer_handle;

  modport source (output valid, output operation, output buffer_key,
                  output buffer_handle, input ready);
  modport sink   (input valid, input operation, input buffer_key,
                  input buffer_handle, output ready);
endinterface

interface gbc_out_if import gbc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [OUT_HANDLE_W-1:0] found_handle;
  logic                    insert_dropped;

  modport source (output valid, output hit, output found_handle,
                  output insert_dropped, input ready);
  modport sink   (input valid, input hit, input found_handle,
                  input insert_dropped, output ready);
endinterface

`default_nettype wire

[rtl/gbc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the key, handle and age stores.
`default_nettype none

module gbc_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and a registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/gbc_ctrl.sv]
// Controller of the generational buffer cache: accept, scan, commit.
// Depends on gbc_pkg for the state, command and status types.
`default_nettype none

module gbc_ctrl import gbc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // Hold or advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.last_addr) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs; take no word while reset is held
  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = rst_n;
        cmd.start = in_valid && rst_n;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/gbc_dp.sv]
// Datapath of the generational buffer cache: table stores, scan trackers
// and result register. Depends on gbc_pkg and gbc_ram.
`default_nettype none

module gbc_dp import gbc_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int GENERATIONS   = 4,
  parameter int KEY_BITS      = 64,
  parameter int HANDLE_BITS   = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [IN_KEY_W-1:0]     in_buffer_key,
  input  logic [IN_HANDLE_W-1:0]  in_buffer_handle,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic [OUT_HANDLE_W-1:0] out_found_handle,
  output logic                    out_insert_dropped
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int AGE_W  = (GENERATIONS > 1) ? $clog2(GENERATIONS) : 1;
  localparam int DATA_W = KEY_BITS + HANDLE_BITS;

  // Latched request word
  op_t                   op_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] handle_r;

  // Scan addressing
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] ev_idx_r;
  logic             ev_vld_r;

  // Scan trackers
  logic                   best_found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [AGE_W-1:0]       best_age_r;
  logic [HANDLE_BITS-1:0] best_handle_r;
  logic                   present_r;
  logic                   free_found_r;
  logic [IDX_W-1:0]       free_idx_r;

  // Entry valid bits
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  // Result register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r;
  logic [OUT_HANDLE_W-1:0] out_handle_r;
  logic                    out_drop_r;

  // Store ports
  logic [DATA_W-1:0] data_rdata;
  logic              data_we;
  logic [AGE_W-1:0]  age_rdata;
  logic              age_we;
  logic [IDX_W-1:0]  age_waddr;
  logic [AGE_W-1:0]  age_wdata;

  // Entry under evaluation
  logic                   ev_valid;
  logic [KEY_BITS-1:0]    ev_key;
  logic [HANDLE_BITS-1:0] ev_handle;
  logic                   key_eq;
  logic [AGE_W:0]         age_inc;
  logic                   age_drop;
  logic                   ins_ok;

  assign ev_valid  = valid_r[ev_idx_r];
  assign ev_key    = data_rdata[DATA_W-1:HANDLE_BITS];
  assign ev_handle = data_rdata[HANDLE_BITS-1:0];
  assign key_eq    = (ev_key == key_r);
  assign age_inc   = (AGE_W+1)'(age_rdata) + (AGE_W+1)'(1);
  assign age_drop  = (age_inc >= (AGE_W+1)'(GENERATIONS));
  assign ins_ok    = !present_r && free_found_r;

  assign status.last_addr = (rd_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign status.out_free  = !out_valid_r || out_ready;

  // Key and handle store
  assign data_we = cmd.finish && (op_r == OP_REGISTER) && ins_ok;

  gbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (free_idx_r),
    .wdata ({key_r, handle_r}),
    .raddr (rd_idx_r),
    .rdata (data_rdata)
  );

  // Age store write: aging during refresh, reset to zero on commit
  always_comb begin
    age_we    = 1'b0;
    age_waddr = ev_idx_r;
    age_wdata = '0;
    if (ev_vld_r && (op_r == OP_REFRESH) && ev_valid && !age_drop) begin
      age_we    = 1'b1;
      age_wdata = age_inc[AGE_W-1:0];
    end
    if (cmd.finish) begin
      if ((op_r == OP_LOOKUP) && best_found_r) begin
        age_we    = 1'b1;
        age_waddr = best_idx_r;
      end else if ((op_r == OP_REGISTER) && ins_ok) begin
        age_we    = 1'b1;
        age_waddr = free_idx_r;
      end
    end
  end

  gbc_ram #(
    .WIDTH (AGE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (rd_idx_r),
    .rdata (age_rdata)
  );

  // Latch the word and advance the read address
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r     <= op_t'(in_operation);
      key_r    <= KEY_BITS'(in_buffer_key);
      handle_r <= HANDLE_BITS'(in_buffer_handle);
      rd_idx_r <= '0;
    end else if (cmd.scan) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
    ev_idx_r <= rd_idx_r;
  end

  // Read data is valid in the cycle after each issued read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_vld_r <= 1'b0;
    end else begin
      ev_vld_r <= cmd.scan;
    end
  end

  // Track best match, presence at age zero and first free entry
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_found_r <= 1'b0;
      present_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ev_vld_r) begin
      unique case (op_r)
        OP_LOOKUP: begin
          if (ev_valid && key_eq && (!best_found_r || (age_rdata < best_age_r))) begin
            best_found_r  <= 1'b1;
            best_idx_r    <= ev_idx_r;
            best_age_r    <= age_rdata;
            best_handle_r <= ev_handle;
          end
        end
        OP_REGISTER: begin
          if (ev_valid && key_eq && (age_rdata == '0)) begin
            present_r <= 1'b1;
          end
          if (!ev_valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= ev_idx_r;
          end
        end
        OP_REFRESH: begin
        end
        OP_PURGE: begin
        end
      endcase
    end
  end

  // Valid bits: drop aged-out entries, set on insert, clear on purge
  always_comb begin
    valid_nxt = valid_r;
    if (ev_vld_r && (op_r == OP_REFRESH) && ev_valid && age_drop) begin
      valid_nxt[ev_idx_r] = 1'b0;
    end
    if (cmd.finish) begin
      if ((op_r == OP_REGISTER) && ins_ok) begin
        valid_nxt[free_idx_r] = 1'b1;
      end else if (op_r == OP_PURGE) begin
        valid_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result register: load on commit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit_r    <= (op_r == OP_LOOKUP) && best_found_r;
      out_handle_r <= ((op_r == OP_LOOKUP) && best_found_r)
                      ? OUT_HANDLE_W'(best_handle_r) : '0;
      out_drop_r   <= (op_r == OP_REGISTER) && !present_r && !free_found_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_found_handle   = out_handle_r;
  assign out_insert_dropped = out_drop_r;

endmodule

`default_nettype wire

[rtl/generational_buffer_cache_core.sv]
// Top level of the generational buffer cache: controller plus datapath.
// Depends on gbc_pkg, gbc_if, gbc_ram, gbc_ctrl and gbc_dp.
//
//   Channel   Dir  Handshake          Payload
//   in_chan   in   valid / ready      operation, buffer_key, buffer_handle
//   out_chan  out  valid / ready      hit, found_handle, insert_dropped
//
// Every word passes through the accept cycle, one read of the stores per
// entry, a drain state for the last read to return and a commit, which
// waits until the result register is free; its result is registered at commit.
// rst_n is synchronous; it clears the entry valid bits, so the table is
// empty and usable in the cycle after reset, with no clearing pass.
// A result waits in the output register while the next word is scanned;
// the commit of that next word stalls until the register is free.
`default_nettype none

module generational_buffer_cache_core import gbc_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int GENERATIONS   = 4,
  parameter int KEY_BITS      = 64,
  parameter int HANDLE_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  gbc_in_if.sink     in_chan,
  gbc_out_if.source  out_chan
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_chan.ready = in_ready;

  // Sequencing of accept, scan and commit
  gbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table stores and result register
  gbc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .GENERATIONS   (GENERATIONS),
    .KEY_BITS      (KEY_BITS),
    .HANDLE_BITS   (HANDLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_operation       (in_chan.operation),
    .in_buffer_key      (in_chan.buffer_key),
    .in_buffer_handle   (in_chan.buffer_handle),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_hit            (out_chan.hit),
    .out_found_handle   (out_chan.found_handle),
    .out_insert_dropped (out_chan.insert_dropped)
  );

endmodule

`default_nettype wire
